>>> sv/xed_pkg.sv
// Package for the XML character entity decoder: word types, number mode
// encoding and the character codes the decoder recognizes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package xed_pkg;

  localparam int WinDepth = 6;
  localparam int MaxOut   = 8;
  localparam int NarrowW  = 14;

  // Magnitude limits that decide how many value bytes a numeric reference emits.
  localparam logic [31:0] Lim3Byte = 32'hFF_FFFF;
  localparam logic [31:0] Lim2Byte = 32'h00_FFFF;
  localparam logic [31:0] Lim1Byte = 32'h00_00FF;

  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowG    = 8'h67;
  localparam logic [7:0] ChLowL    = 8'h6C;
  localparam logic [7:0] ChLowM    = 8'h6D;
  localparam logic [7:0] ChLowO    = 8'h6F;
  localparam logic [7:0] ChLowP    = 8'h70;
  localparam logic [7:0] ChLowQ    = 8'h71;
  localparam logic [7:0] ChLowS    = 8'h73;
  localparam logic [7:0] ChLowT    = 8'h74;
  localparam logic [7:0] ChLowU    = 8'h75;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChApos    = 8'h27;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChLowF    = 8'h66;

  typedef enum logic [2:0] {
    ModeText = 3'b001,
    ModeDec  = 3'b010,
    ModeHex  = 3'b100
  } xed_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } xed_out_t;

  // All result words caused by one input word.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [3:0]             cnt;
    logic                   last;
  } xed_pkt_t;

  typedef struct packed {
    logic [2:0] cnt;
    xed_mode_e  mode;
  } xed_stat_t;

  // Returns {valid, value} for a decimal digit, or a hex digit when hex is set.
  function automatic logic [4:0] digit_val(logic [7:0] b, logic hex);
    logic [4:0] r;
    r = '0;
    if (b >= ChZero && b <= ChNine) begin
      r = {1'b1, b[3:0]};
    end else if (hex && ((b >= ChUpA && b <= ChUpF) || (b >= ChLowA && b <= ChLowF))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> sv/xml_entity_decoder.sv
// XML character entity decoder, top level. Depends on xed_pkg, xed_core, xed_obuf.
// The first decoded word of an input word is offered in the cycle after that word is accepted.
// Throughput: one input word per cycle while each decodes to at most one word and the output is
// not stalled; longer results hold the input until the one-word-per-cycle result register drains.
// Reset (rst_ni, asynchronous, active low) clears the window count, the numeric reference state
// and the result register's count and read index; the window and result bytes are not reset.
`timescale 1ns / 1ps

module xml_entity_decoder import xed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  xed_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output xed_out_t out_data_o
);

  logic      accept;
  logic      free;
  xed_pkt_t  pkt;
  xed_stat_t stat;

  assign accept     = in_valid_i && free;
  assign in_stall_o = !free;

  xed_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .pkt_o     (pkt),
    .stat_o    (stat)
  );

  xed_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .pkt_i       (pkt),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The string's final word leaves no pending bytes and no open reference.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.in_last |=> stat.cnt == '0 && stat.mode == ModeText)
    else $error("state not cleared after final word");

  // While a numeric reference is open, every window byte has been consumed.
  a_num_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.mode != ModeText |-> stat.cnt == '0)
    else $error("window holds bytes inside a numeric reference");

  // Between words the window never holds a full lookahead.
  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt < 3'(WinDepth))
    else $error("window count out of range");

endmodule

>>> sv/xed_core.sv
// Decode core: lookahead window, numeric reference state and the single-pass
// logic that turns one text word into a packet of decoded bytes.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_core import xed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  xed_in_t   in_data_i,
  output xed_pkt_t  pkt_o,
  output xed_stat_t stat_o
);

  // Working view of the window while one word is decoded.
  typedef struct packed {
    logic [WinDepth-1:0][7:0] win;
    logic [2:0]               cnt;
    xed_mode_e                mode;
    logic [NarrowW-1:0]       acc;
    logic [MaxOut-1:0][7:0]   ob;
    logic [3:0]               on;
  } xed_work_t;

  function automatic xed_work_t push_byte(xed_work_t s, logic [7:0] b);
    xed_work_t r;
    r = s;
    if (s.on < 4'(MaxOut)) begin
      r.ob[s.on[2:0]] = b;
      r.on = s.on + 4'd1;
    end
    return r;
  endfunction

  // A reference that starts inside the window holds at most four digits.
  function automatic xed_work_t put_narrow(xed_work_t s);
    xed_work_t r;
    r = s;
    if (s.acc > NarrowW'(Lim1Byte)) begin
      r = push_byte(r, 8'(s.acc[NarrowW-1:8]));
    end
    if (s.acc != '0) begin
      r = push_byte(r, s.acc[7:0]);
    end
    return r;
  endfunction

  function automatic xed_work_t put_wide(xed_work_t s, logic [31:0] v);
    xed_work_t r;
    r = s;
    if (v > Lim3Byte) r = push_byte(r, v[31:24]);
    if (v > Lim2Byte) r = push_byte(r, v[23:16]);
    if (v > Lim1Byte) r = push_byte(r, v[15:8]);
    if (v != '0)      r = push_byte(r, v[7:0]);
    return r;
  endfunction

  // One decode step at the head of the window: a digit or terminator of an
  // open reference, or a decision on the head once the window is full or flushing.
  function automatic xed_work_t tok_unit(xed_work_t s, logic flush);
    xed_work_t            r;
    logic [WinDepth-1:0][7:0] w;
    logic                 hex;
    logic                 amp;
    logic [4:0]           dv;
    logic [2:0]           drop;
    r    = s;
    w    = s.win;
    hex  = (s.mode == ModeHex);
    amp  = (w[0] == ChAmp);
    dv   = digit_val(w[0], hex);
    drop = '0;
    if (s.cnt != '0) begin
      if (s.mode != ModeText) begin
        drop = 3'd1;
        if (dv[4]) begin
          r.acc = hex ? {s.acc[NarrowW-5:0], dv[3:0]}
                      : (s.acc << 3) + (s.acc << 1) + NarrowW'(dv[3:0]);
        end else begin
          r      = put_narrow(r);
          r.mode = ModeText;
          r.acc  = '0;
        end
      end else if (flush || s.cnt == 3'(WinDepth)) begin
        priority if (s.cnt >= 3'd5 && amp && w[1] == ChHash && w[2] == ChLowX) begin
          r.mode = ModeHex;
          r.acc  = '0;
          drop   = 3'd3;
        end else if (s.cnt >= 3'd4 && amp && w[1] == ChHash) begin
          r.mode = ModeDec;
          r.acc  = '0;
          drop   = 3'd2;
        end else if (s.cnt >= 3'd4 && amp && w[1] == ChLowL && w[2] == ChLowT
                     && w[3] == ChSemi) begin
          r    = push_byte(r, ChLess);
          drop = 3'd4;
        end else if (s.cnt >= 3'd4 && amp && w[1] == ChLowG && w[2] == ChLowT
                     && w[3] == ChSemi) begin
          r    = push_byte(r, ChGreater);
          drop = 3'd4;
        end else if (s.cnt >= 3'd6 && amp && w[1] == ChLowQ && w[2] == ChLowU
                     && w[3] == ChLowO && w[4] == ChLowT && w[5] == ChSemi) begin
          r    = push_byte(r, ChQuote);
          drop = 3'd6;
        end else if (s.cnt >= 3'd6 && amp && w[1] == ChLowA && w[2] == ChLowP
                     && w[3] == ChLowO && w[4] == ChLowS && w[5] == ChSemi) begin
          r    = push_byte(r, ChApos);
          drop = 3'd6;
        end else if (s.cnt >= 3'd5 && amp && w[1] == ChLowA && w[2] == ChLowM
                     && w[3] == ChLowP && w[4] == ChSemi) begin
          r    = push_byte(r, ChAmp);
          drop = 3'd5;
        end else begin
          r    = push_byte(r, w[0]);
          drop = 3'd1;
        end
      end
    end
    r.win = s.win >> {drop, 3'b000};
    r.cnt = s.cnt - drop;
    return r;
  endfunction

  logic [WinDepth-1:0][7:0] win_q, win_d;
  logic [2:0]               cnt_q, cnt_d;
  xed_mode_e                mode_q, mode_d;
  logic [31:0]              acc_q, acc_d;

  xed_work_t                chain [WinDepth+1];
  xed_work_t                done_w;
  xed_work_t                wide_w;
  logic [4:0]               dv;
  logic [31:0]              acc_step;

  always_comb begin
    dv       = digit_val(in_data_i.in_byte, mode_q == ModeHex);
    acc_step = (mode_q == ModeHex) ? {acc_q[27:0], dv[3:0]}
                                   : (acc_q << 3) + (acc_q << 1) + 32'(dv[3:0]);

    // Text path: append the word, then at most one head step per window byte.
    chain[0]      = '0;
    chain[0].win  = win_q;
    chain[0].win[cnt_q] = in_data_i.in_byte;
    chain[0].cnt  = cnt_q + 3'd1;
    chain[0].mode = ModeText;
    for (int i = 0; i < WinDepth; i++) begin
      chain[i+1] = tok_unit(chain[i], in_data_i.in_last);
    end
    done_w = chain[WinDepth];
    if (in_data_i.in_last && done_w.mode != ModeText) begin
      done_w = put_narrow(done_w);
    end

    // Number path: the window is empty while a reference is open.
    wide_w      = '0;
    wide_w.mode = ModeText;

    win_d = win_q;
    if (mode_q != ModeText) begin
      cnt_d = '0;
      if (dv[4]) begin
        mode_d = mode_q;
        acc_d  = acc_step;
        if (in_data_i.in_last) begin
          wide_w = put_wide(wide_w, acc_step);
        end
      end else begin
        wide_w = put_wide(wide_w, acc_q);
        mode_d = ModeText;
        acc_d  = '0;
      end
      pkt_o.data = wide_w.ob;
      pkt_o.cnt  = wide_w.on;
    end else begin
      win_d      = done_w.win;
      cnt_d      = done_w.cnt;
      mode_d     = done_w.mode;
      acc_d      = 32'(done_w.acc);
      pkt_o.data = done_w.ob;
      pkt_o.cnt  = done_w.on;
    end
    pkt_o.last = in_data_i.in_last;

    if (in_data_i.in_last) begin
      cnt_d  = '0;
      mode_d = ModeText;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= ModeText;
      acc_q  <= '0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

  assign stat_o.cnt  = cnt_q;
  assign stat_o.mode = mode_q;

endmodule

>>> sv/xed_obuf.sv
// Result register: holds the decoded bytes of one input word and hands them
// out one word per cycle on the output channel while it is not stalled.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_obuf import xed_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  xed_pkt_t pkt_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output xed_out_t out_data_o
);

  logic [MaxOut-1:0][7:0] data_q;
  logic [3:0]             cnt_q;
  logic [2:0]             rd_q;
  logic                   last_q;
  logic                   pop;
  logic                   at_end;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign at_end      = ({1'b0, rd_q} + 4'd1 == cnt_q);
  // A new packet may enter in the cycle its predecessor's final word leaves.
  assign free_o      = !out_valid_o || (pop && at_end);

  assign out_data_o.out_byte = data_q[rd_q];
  assign out_data_o.out_last = last_q && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= pkt_i.cnt;
      rd_q  <= '0;
    end else if (pop) begin
      if (at_end) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= pkt_i.data;
      last_q <= pkt_i.last;
    end
  end

endmodule
